// ----- rtl/argb_to_mono_page_framebuffer_assert.svh -----
// Assertion macros shared by the frame buffer modules.
`ifndef ARGB_TO_MONO_PAGE_FRAMEBUFFER_ASSERT_SVH
`define ARGB_TO_MONO_PAGE_FRAMEBUFFER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define AFB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define AFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AFB_ASSERT_NOW(lbl, ante, cons, msg)
`define AFB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/afb_pkg.sv -----
// Types and constants shared by the page frame buffer modules.
`timescale 1ns / 1ps

package afb_pkg;

    // Display geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_ROWS     = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int BANK_W        = $clog2(PAGE_ROWS);

    // Field widths
    localparam int CMD_W      = 2;
    localparam int X_W        = 7;
    localparam int Y_W        = 6;
    localparam int WIDTH_W    = 8;
    localparam int HEIGHT_W   = 7;
    localparam int ARGB_W     = 32;
    localparam int INDEX_W    = 10;
    localparam int DATA_W     = 8;
    localparam int CHAN_W     = 8;

    // Position registers: origin plus cursor may run past the display
    localparam int POS_X_W    = 9;
    localparam int POS_Y_W    = 8;
    // Sum of three channels, and three times the threshold
    localparam int SUM_W      = 10;

    localparam int THRESHOLD_RESET = 128;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic {
        KIND_DONE = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    // One classified operation for the back end
    typedef struct packed {
        logic              wr_en;     // write one pixel bit
        logic [BANK_W-1:0] bank;      // row within the page
        logic              bit_val;   // lit or dark
        logic              res_en;    // produce a result word
        kind_t             res_kind;
        logic [ADDR_W-1:0] addr;      // write address, or read index
        logic              in_store;  // read index lies inside the store
    } op_t;

endpackage

// ----- rtl/afb_front.sv -----
// Command decode, rectangle cursor tracking and pixel thresholding.
`timescale 1ns / 1ps

module afb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [afb_pkg::CMD_W-1:0]     command,
    input  logic [afb_pkg::X_W-1:0]       area_x,
    input  logic [afb_pkg::Y_W-1:0]       area_y,
    input  logic [afb_pkg::WIDTH_W-1:0]   area_width,
    input  logic [afb_pkg::HEIGHT_W-1:0]  area_height,
    input  logic [afb_pkg::ARGB_W-1:0]    pixel_argb,
    input  logic [afb_pkg::INDEX_W-1:0]   read_index,
    input  logic [afb_pkg::CHAN_W-1:0]    threshold,
    output logic                          push,
    output afb_pkg::op_t                  op
);
    import afb_pkg::*;

    logic [X_W-1:0]      origin_x_reg, origin_x_next;
    logic [WIDTH_W-1:0]  width_reg,    width_next;
    logic [HEIGHT_W-1:0] height_reg,   height_next;
    logic [WIDTH_W-1:0]  col_reg,      col_next;
    logic [HEIGHT_W-1:0] row_reg,      row_next;
    logic [POS_X_W-1:0]  px_reg,       px_next;
    logic [POS_Y_W-1:0]  py_reg,       py_next;

    logic [SUM_W-1:0]    gray_sum;
    logic [SUM_W-1:0]    level3;
    logic                lit;
    logic                on_screen;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic                need_push;

    // gray >= threshold with gray = sum / 3 is the same as sum >= 3 * threshold
    assign gray_sum = SUM_W'(pixel_argb[23:16]) + SUM_W'(pixel_argb[15:8])
                    + SUM_W'(pixel_argb[7:0]);
    assign level3   = SUM_W'(threshold) + {1'b0, threshold, 1'b0};
    assign lit      = (gray_sum >= level3);

    assign on_screen = (px_reg < POS_X_W'(SCREEN_WIDTH)) && (py_reg < POS_Y_W'(SCREEN_HEIGHT));
    assign col_inc   = col_reg + WIDTH_W'(1);
    assign row_inc   = row_reg + HEIGHT_W'(1);

    always_comb
    begin
        origin_x_next = origin_x_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        op            = '0;
        op.res_kind   = KIND_DONE;
        need_push     = 1'b0;
        case (cmd_t'(command))
            CMD_BEGIN:
            begin
                origin_x_next = area_x;
                width_next    = area_width;
                col_next      = '0;
                row_next      = '0;
                px_next       = POS_X_W'(area_x);
                py_next       = POS_Y_W'(area_y);
                if ((area_width == '0) || (area_height == '0))
                begin
                    // empty rectangle: finish at once, leave nothing active
                    height_next = '0;
                    op.res_en   = 1'b1;
                    need_push   = 1'b1;
                end
                else
                begin
                    height_next = area_height;
                end
            end
            CMD_PIXEL:
            begin
                if (row_reg < height_reg)
                begin
                    op.wr_en   = on_screen;
                    op.bank    = py_reg[BANK_W-1:0];
                    op.bit_val = lit;
                    op.addr    = ADDR_W'(py_reg[POS_Y_W-1:BANK_W]) * ADDR_W'(SCREEN_WIDTH)
                               + ADDR_W'(px_reg);
                    if (col_inc >= width_reg)
                    begin
                        // wrap to the next row of the rectangle
                        col_next = '0;
                        row_next = row_inc;
                        px_next  = POS_X_W'(origin_x_reg);
                        py_next  = py_reg + POS_Y_W'(1);
                        op.res_en = (row_inc >= height_reg);
                    end
                    else
                    begin
                        col_next = col_inc;
                        px_next  = px_reg + POS_X_W'(1);
                    end
                    need_push = op.wr_en || op.res_en;
                end
            end
            CMD_READ:
            begin
                op.res_en   = 1'b1;
                op.res_kind = KIND_READ;
                op.addr     = ADDR_W'(read_index);
                op.in_store = ((INDEX_W+1)'(read_index) < (INDEX_W+1)'(STORE_BYTES));
                need_push   = 1'b1;
            end
            default:
            begin
                need_push = 1'b0;
            end
        endcase
    end

    assign push = accept && need_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
        end
        else if (accept)
        begin
            origin_x_reg <= origin_x_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
        end
    end

endmodule

// ----- rtl/afb_queue.sv -----
// Short operation queue between the front and back ends.
`timescale 1ns / 1ps
`include "argb_to_mono_page_framebuffer_assert.svh"

module afb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  afb_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output afb_pkg::op_t  head_op
);
    import afb_pkg::*;

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    `AFB_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `AFB_ASSERT_NOW(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")
    `AFB_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1), "lost push")

endmodule

// ----- rtl/afb_back.sv -----
// Frame store banks, clearing sweep and result output register.
`timescale 1ns / 1ps
`include "argb_to_mono_page_framebuffer_assert.svh"

module afb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  afb_pkg::op_t                  head_op,
    output logic                          pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [afb_pkg::DATA_W-1:0]    read_data,
    output logic [afb_pkg::INDEX_W-1:0]   byte_index
);
    import afb_pkg::*;

    logic                  clearing_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  res_valid_reg, res_valid_next;
    kind_t                 res_kind_reg;
    logic [INDEX_W-1:0]    res_index_reg;
    logic                  res_in_store_reg;

    logic                  res_free;
    logic                  load_res;
    logic                  rd_en;
    logic [PAGE_ROWS-1:0]  bank_we;
    logic [ADDR_W-1:0]     bank_addr;
    logic                  bank_wd;
    logic [DATA_W-1:0]     rd_word;

    assign res_free = !res_valid_reg || out_ready;
    assign pop      = head_valid && !clearing_reg && (!head_op.res_en || res_free);
    assign load_res = pop && head_op.res_en;
    assign rd_en    = load_res && (head_op.res_kind == KIND_READ);
    assign clearing = clearing_reg;

    // Clear sweeps every bank at once; otherwise write the single addressed row
    always_comb
    begin
        if (clearing_reg)
        begin
            bank_we   = '1;
            bank_addr = clr_addr_reg;
            bank_wd   = 1'b0;
        end
        else
        begin
            bank_we   = (pop && head_op.wr_en) ? (PAGE_ROWS'(1) << head_op.bank) : '0;
            bank_addr = head_op.addr;
            bank_wd   = head_op.bit_val;
        end
    end

    for (genvar b = 0; b < PAGE_ROWS; b++)
    begin : g_bank
        logic bank_mem [STORE_BYTES];
        logic rd_bit_reg;

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                bank_mem[bank_addr] <= bank_wd;
            end
            if (rd_en)
            begin
                rd_bit_reg <= bank_mem[head_op.addr];
            end
        end

        assign rd_word[b] = rd_bit_reg;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_kind_reg     <= head_op.res_kind;
            res_in_store_reg <= head_op.in_store;
            res_index_reg    <= (head_op.res_kind == KIND_READ) ? INDEX_W'(head_op.addr) : '0;
        end
    end

    assign out_valid  = res_valid_reg;
    assign kind       = res_kind_reg;
    assign read_data  = ((res_kind_reg == KIND_READ) && res_in_store_reg) ? rd_word : '0;
    assign byte_index = res_index_reg;

    `AFB_ASSERT_NOW(a_no_pop_clear, clearing_reg, !pop, "queue drained during clear")
    `AFB_ASSERT_NOW(a_res_room, load_res, res_free, "result overwrites waiting word")
    `AFB_ASSERT_NOW(a_clear_len, $fell(clearing_reg), $past(clr_addr_reg) == ADDR_W'(STORE_BYTES - 1), "clear sweep ended early")

endmodule

// ----- rtl/argb_to_mono_page_framebuffer.sv -----
// Top level of the ARGB to one-bit page-layout frame buffer.
`timescale 1ns / 1ps

// 128 x 64 one-bit frame store in page layout (byte = page * 128 + column, bit n = row n of
// the page), fed with 32-bit ARGB words. A begin word latches a rectangle, pixel words fill it
// in row-major order, and a pixel lights when (R + G + B) / 3 >= threshold; off-screen pixels
// are dropped but still move the cursor. A done word follows the rectangle's last pixel, or
// comes at once for an empty rectangle. A read word returns one store byte. Rate: one input
// word per clock sustained, in any mix of commands, while out_ready stays high; a result word
// is queued at the edge that takes its command, then popped into the output register along
// with the registered bank read once that register is free.
// The store is eight 1024 x 1 banks, one per row of a page, so a pixel is a single bit write
// with no read-modify-write. After reset a clearing sweep zeroes the store, and while it runs
// in_ready stays low; threshold writes are taken throughout.

module argb_to_mono_page_framebuffer (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          threshold_wr_en,
    input  logic [afb_pkg::CHAN_W-1:0]    threshold_wr_data,
    // input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [afb_pkg::CMD_W-1:0]     command,
    input  logic [afb_pkg::X_W-1:0]       area_x,
    input  logic [afb_pkg::Y_W-1:0]       area_y,
    input  logic [afb_pkg::WIDTH_W-1:0]   area_width,
    input  logic [afb_pkg::HEIGHT_W-1:0]  area_height,
    input  logic [afb_pkg::ARGB_W-1:0]    pixel_argb,
    input  logic [afb_pkg::INDEX_W-1:0]   read_index,
    // result words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [afb_pkg::DATA_W-1:0]    read_data,
    output logic [afb_pkg::INDEX_W-1:0]   byte_index
);
    import afb_pkg::*;

    logic [CHAN_W-1:0] threshold_reg;
    logic              accept;
    logic              push;
    op_t               push_op;
    logic              q_full;
    logic              pop;
    logic              head_valid;
    op_t               head_op;
    logic              clearing;

    // Hold the threshold; the user must change it only while the block is idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= CHAN_W'(THRESHOLD_RESET);
        end
        else if (threshold_wr_en)
        begin
            threshold_reg <= threshold_wr_data;
        end
    end

    // Take a word whenever no clear is running and the queue has room; the back end drains
    // it in order, so while a result waits on out_ready the next queued op that makes a result
    // holds back whatever is queued behind it, and the input stalls once both slots are taken
    assign in_ready = !clearing && !q_full;
    assign accept   = in_valid && in_ready;

    // Front: decode, advance the rectangle cursor, threshold the pixel
    afb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .area_x      (area_x),
        .area_y      (area_y),
        .area_width  (area_width),
        .area_height (area_height),
        .pixel_argb  (pixel_argb),
        .read_index  (read_index),
        .threshold   (threshold_reg),
        .push        (push),
        .op          (push_op)
    );

    // Queue: decouple classification from store access and result delivery
    afb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Back: write pixel bits, read bytes, present result words
    afb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .read_data  (read_data),
        .byte_index (byte_index)
    );

endmodule
